// File: rtl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the multi-click detector
// Holds the sample record, the event codes and the click window reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

   // Widths of the fields
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned WindowWidth = 15;
   localparam int unsigned EventWidth  = 2;

   // Click window after reset, in milliseconds
   localparam logic [WindowWidth-1:0] WINDOW_RESET = 15'd600;

   // Button levels
   localparam logic LEVEL_PRESSED  = 1'b1;
   localparam logic LEVEL_RELEASED = 1'b0;

   // Event codes reported per item
   typedef enum logic [EventWidth-1:0] {
      EVT_NONE   = 2'd0,
      EVT_SINGLE = 2'd1,
      EVT_DOUBLE = 2'd2,
      EVT_TRIPLE = 2'd3
   } event_type;

   // One button sample
   typedef struct packed {
      logic                 level;
      logic [TimeWidth-1:0] now_ms;
   } sample_type;

endpackage : mcd_pkg

`default_nettype wire

// File: rtl/mcd_fsm.sv
// ----------------------------------------------------------------------------
// mcd_fsm: click counting state machine with result register
// Follows press/release phases, times the window from the first press and
// registers one event code for each sample stepped through it.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_fsm
   import mcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire sample_type             sample,
   input  wire logic [WindowWidth-1:0] click_window,
   output logic      [EventWidth-1:0]  click_event
);

   typedef enum logic [2:0] {
      IDLE   = 3'd0,
      PRESS1 = 3'd1,
      REL1   = 3'd2,
      PRESS2 = 3'd3,
      REL2   = 3'd4,
      PRESS3 = 3'd5,
      REL3   = 3'd6
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [TimeWidth-1:0] first_time_ff, first_time_in;
   event_type            event_ff, event_in;
   logic [TimeWidth-1:0] deadline;
   logic                 window_over;

   // Deadline wraps at 32 bits, compare unsigned
   assign deadline    = first_time_ff + {{(TimeWidth-WindowWidth){1'b0}}, click_window};
   assign window_over = sample.now_ms > deadline;

   // Next phase and event for the sample at hand
   always_comb begin
      phase_in      = phase_ff;
      first_time_in = first_time_ff;
      event_in      = EVT_NONE;
      case (phase_ff)
         IDLE: begin
            if (sample.level == LEVEL_PRESSED) begin
               phase_in      = PRESS1;
               first_time_in = sample.now_ms;
            end
         end
         PRESS1: begin
            if (sample.level == LEVEL_RELEASED) phase_in = REL1;
         end
         PRESS2: begin
            if (sample.level == LEVEL_RELEASED) phase_in = REL2;
         end
         PRESS3: begin
            if (sample.level == LEVEL_RELEASED) phase_in = REL3;
         end
         // Timeout wins over a press in the same sample
         REL1: begin
            if (window_over) begin
               event_in = EVT_SINGLE;
               phase_in = IDLE;
            end else if (sample.level == LEVEL_PRESSED) begin
               phase_in = PRESS2;
            end
         end
         REL2: begin
            if (window_over) begin
               event_in = EVT_DOUBLE;
               phase_in = IDLE;
            end else if (sample.level == LEVEL_PRESSED) begin
               phase_in = PRESS3;
            end
         end
         // Further presses are ignored after the third release
         REL3: begin
            if (window_over) begin
               event_in = EVT_TRIPLE;
               phase_in = IDLE;
            end
         end
         default: begin
            phase_in = IDLE;
         end
      endcase
   end

   // Hold state, advance on each stepped sample
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= IDLE;
         first_time_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         first_time_ff <= first_time_in;
         event_ff      <= event_in;
      end
   end

   assign click_event = event_ff;

endmodule : mcd_fsm

`default_nettype wire

// File: rtl/multi_click_detector.sv
// ----------------------------------------------------------------------------
// multi_click_detector: single, double and triple click detection
// Input register, click state machine and result register in one pass.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one button sample per item (req_level, req_now_ms).
//   rsp_ channel: one event code per sample (rsp_click_event), 0 none,
//   1 single, 2 double, 3 triple click, in sample order.
//   csr_ port: csr_wr_en with csr_wr_data loads the click window (ms).
// Pipeline: a sample accepted into the input register moves on into the result
//   register once the result register is free; the input register and the
//   result register each hold one item.
// Throughput: one item per cycle, set by the single FSM step, unless stalled.
// Reset: phase goes to idle, first press time to 0, window to 600 ms, both
//   item registers empty; req_stall is low after reset.
// Stall: when rsp_stall holds a result, the input register still takes one
//   more item, then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_click_detector
   import mcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_level,
   input  wire logic [TimeWidth-1:0]   req_now_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [EventWidth-1:0]  rsp_click_event,
   input  wire logic                   csr_wr_en,
   input  wire logic [WindowWidth-1:0] csr_wr_data
);

   logic [WindowWidth-1:0] click_window_ff;
   logic                   in_valid_ff;
   sample_type             sample_ff;
   logic                   rsp_valid_ff;
   logic                   req_fire;
   logic                   advance;

   // Move the held item on when the result register is free or drains
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   // Click window register
   always_ff @(posedge clock) begin
      if (reset) begin
         click_window_ff <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         click_window_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff.level  <= req_level;
         sample_ff.now_ms <= req_now_ms;
      end
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   mcd_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .sample       (sample_ff),
      .click_window (click_window_ff),
      .click_event  (rsp_click_event)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule : multi_click_detector

`default_nettype wire

// File: rtl/mcd_checker.sv
// ----------------------------------------------------------------------------
// mcd_checker: port level checks of the multi-click detector
// Watches the request, result and reset behavior seen on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_checker
   import mcd_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [EventWidth-1:0]  rsp_click_event
);

   // Reset empties both item registers
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("items left after reset");

   // A held result keeps its value
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_click_event)))
      else $error("stalled result changed");

   // With the result register empty the input side never stalls
   a_no_idle_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result register");

   // A stall on the request side only follows a stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stall without result stall");

endmodule : mcd_checker

bind multi_click_detector mcd_checker u_mcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_click_event (rsp_click_event)
);

`default_nettype wire
